/* design/hmkv_pkg.sv */
// ============================================================================
// hmkv_pkg
// Shared types for the hash map key-value store: request and response
// transfer structs and the operation codes.
// ============================================================================
package hmkv_pkg;

    localparam int FIELD_W = 31;

    typedef enum logic [1:0] {
        OP_PUT    = 2'd0,
        OP_GET    = 2'd1,
        OP_REMOVE = 2'd2
    } t_op;

    typedef struct packed {
        t_op                operation;
        logic [FIELD_W-1:0] key;
        logic [FIELD_W-1:0] data_in;
    } t_req;

    typedef struct packed {
        logic               found;
        logic [FIELD_W-1:0] data_out;
        logic               status;
    } t_rsp;

endpackage

/* design/hash_map_key_value_store.sv */
// ============================================================================
// hash_map_key_value_store
// Fixed-size hash map, NUM_BUCKETS buckets of WAYS ways, one bucket row per
// memory word. Read row, compare all ways, write row back.
// Flow: for a power-of-two NUM_BUCKETS the row is read as the request is
//   taken; otherwise a two-step reciprocal modulo (S_DIV, S_REM) yields the
//   bucket first. S_EXEC writes the row back; the result strobe is registered.
// Busy stays high from an accepted request until its row write on the single
// memory port pair, and during the reset clearing pass over the row memory.
// ============================================================================
module hash_map_key_value_store #(
    parameter int NUM_BUCKETS = 64,
    parameter int WAYS        = 8,
    parameter int KEY_BITS    = 31
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  hmkv_pkg::t_req  i_req,
    output logic            o_valid,
    output hmkv_pkg::t_rsp  o_rsp
);

    localparam int FW      = hmkv_pkg::FIELD_W;
    localparam int KW      = (KEY_BITS < FW) ? KEY_BITS : FW;
    localparam int BW      = $clog2(NUM_BUCKETS);
    localparam int WW      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam bit IS_POW2 = (NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0;
    localparam int DIV_SH  = FW + BW;
    localparam logic [63:0] DIV_MUL =
        ((64'd1 << DIV_SH) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS);

    typedef struct packed {
        logic          valid;
        logic [KW-1:0] key;
        logic [FW-1:0] value;
    } t_entry;

    typedef t_entry [WAYS-1:0] t_row;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_REM,
        S_EXEC
    } t_state;

    t_state          r_state;
    logic [BW-1:0]   r_clr_addr;
    hmkv_pkg::t_op   r_op;
    logic [KW-1:0]   r_key;
    logic [FW-1:0]   r_data;
    logic [FW-1:0]   r_q;
    logic [BW-1:0]   r_bucket;
    t_row            r_row;
    logic            r_valid;
    hmkv_pkg::t_rsp  r_rsp;

    t_row            mem [NUM_BUCKETS];

    logic            w_accept;
    logic [KW-1:0]   w_in_key;
    logic [FW-1:0]   w_key_ext;
    logic [FW-1:0]   w_rem;
    logic            w_rd_en;
    logic [BW-1:0]   w_rd_addr;
    logic            w_wr_en;
    logic [BW-1:0]   w_wr_addr;
    t_row            w_wr_row;
    logic            w_hit_any;
    logic [WW-1:0]   w_hit_way;
    logic            w_free_any;
    logic [WW-1:0]   w_free_way;
    t_row            w_new_row;
    hmkv_pkg::t_rsp  w_rsp;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_in_key = i_req.key[KW-1:0];
    assign w_key_ext = FW'(r_key);
    assign w_rem    = w_key_ext - FW'(64'(r_q) * 64'(NUM_BUCKETS));

    // read port
    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = '0;
        if (r_state == S_IDLE && w_accept && IS_POW2) begin
            w_rd_en   = 1'b1;
            w_rd_addr = BW'(FW'(w_in_key));
        end else if (r_state == S_REM) begin
            w_rd_en   = 1'b1;
            w_rd_addr = w_rem[BW-1:0];
        end
    end

    // way search, lowest way wins
    always_comb begin
        w_hit_any  = 1'b0;
        w_hit_way  = '0;
        w_free_any = 1'b0;
        w_free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (r_row[w].valid && r_row[w].key == r_key) begin
                w_hit_any = 1'b1;
                w_hit_way = WW'(w);
            end
            if (!r_row[w].valid) begin
                w_free_any = 1'b1;
                w_free_way = WW'(w);
            end
        end
    end

    always_comb begin
        w_new_row = r_row;
        w_rsp     = '0;
        unique case (r_op)
            hmkv_pkg::OP_PUT: begin
                if (w_hit_any) begin
                    w_rsp.found                = 1'b1;
                    w_new_row[w_hit_way].value = r_data;
                end else if (w_free_any) begin
                    w_new_row[w_free_way].valid = 1'b1;
                    w_new_row[w_free_way].key   = r_key;
                    w_new_row[w_free_way].value = r_data;
                end else begin
                    w_rsp.status = 1'b1;
                end
            end
            hmkv_pkg::OP_GET: begin
                if (w_hit_any) begin
                    w_rsp.found    = 1'b1;
                    w_rsp.data_out = r_row[w_hit_way].value;
                end
            end
            hmkv_pkg::OP_REMOVE: begin
                if (w_hit_any) begin
                    w_rsp.found                = 1'b1;
                    w_new_row[w_hit_way].valid = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // write port
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_bucket;
        w_wr_row  = w_new_row;
        if (r_state == S_CLEAR) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_clr_addr;
            w_wr_row  = '0;
        end else if (r_state == S_EXEC) begin
            w_wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= w_wr_row;
        end
        if (w_rd_en) begin
            r_row <= mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= (r_state == S_EXEC);
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == BW'(NUM_BUCKETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_op     <= i_req.operation;
                        r_key    <= w_in_key;
                        r_data   <= i_req.data_in;
                        r_bucket <= w_rd_addr;
                        r_state  <= IS_POW2 ? S_EXEC : S_DIV;
                    end
                end
                S_DIV: begin
                    r_q     <= FW'((64'(w_key_ext) * DIV_MUL) >> DIV_SH);
                    r_state <= S_REM;
                end
                S_REM: begin
                    r_bucket <= w_rd_addr;
                    r_state  <= S_EXEC;
                end
                S_EXEC: begin
                    r_rsp   <= w_rsp;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    a_result_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_EXEC))
        else $error("result strobe without a preceding row update");

    a_free_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("busy while a result transfer is shown");

    a_drop_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.status) |-> (!o_rsp.found && o_rsp.data_out == '0))
        else $error("dropped put reports a hit or data");

endmodule

/* tb/hmkv_checker.sv */
`timescale 1ns / 100ps
// ============================================================================
// hmkv_checker
// Watches the request and response channels of the hash map store. Keeps
// its own bucket/way table, predicts one response per accepted request and
// compares each strobed response against the oldest prediction.
// ============================================================================
module hmkv_checker #(
    parameter int NUM_BUCKETS = 64,
    parameter int WAYS        = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_busy,
    input  hmkv_pkg::t_req i_req,
    input  logic           i_valid,
    input  hmkv_pkg::t_rsp i_rsp,
    output int             o_errors,
    output int             o_pending
);

    localparam int SLOTS = NUM_BUCKETS * WAYS;

    logic                         slot_valid [SLOTS];
    logic [hmkv_pkg::FIELD_W-1:0] slot_key   [SLOTS];
    logic [hmkv_pkg::FIELD_W-1:0] slot_value [SLOTS];

    hmkv_pkg::t_rsp rsp_expected [$];

    function automatic hmkv_pkg::t_rsp apply_request(hmkv_pkg::t_req r);
        hmkv_pkg::t_rsp rsp;
        int   base;
        int   hit;
        int   free_way;
        rsp      = '0;
        base     = int'(r.key % NUM_BUCKETS) * WAYS;
        hit      = -1;
        free_way = -1;
        for (int w = 0; w < WAYS; w++) begin
            if (slot_valid[base + w]) begin
                if (hit < 0 && slot_key[base + w] == r.key) hit = w;
            end else if (free_way < 0) begin
                free_way = w;
            end
        end
        case (r.operation)
            hmkv_pkg::OP_PUT: begin
                if (hit >= 0) begin
                    rsp.found = 1'b1;
                    slot_value[base + hit] = r.data_in;
                end else if (free_way >= 0) begin
                    slot_valid[base + free_way] = 1'b1;
                    slot_key[base + free_way]   = r.key;
                    slot_value[base + free_way] = r.data_in;
                end else begin
                    rsp.status = 1'b1;
                end
            end
            hmkv_pkg::OP_GET: begin
                if (hit >= 0) begin
                    rsp.found    = 1'b1;
                    rsp.data_out = slot_value[base + hit];
                end
            end
            hmkv_pkg::OP_REMOVE: begin
                if (hit >= 0) begin
                    rsp.found = 1'b1;
                    slot_valid[base + hit] = 1'b0;
                end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        hmkv_pkg::t_rsp exp_rsp;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_valid[i] = 1'b0;
                slot_key[i]   = '0;
                slot_value[i] = '0;
            end
            rsp_expected.delete();
            o_errors = 0;
        end else begin
            if (i_valid) begin
                if (rsp_expected.size() == 0) begin
                    $display("%0t: unexpected response found=%0d data_out=%0d status=%0d",
                             $time, i_rsp.found, i_rsp.data_out, i_rsp.status);
                    o_errors++;
                end else begin
                    exp_rsp = rsp_expected.pop_front();
                    if (i_rsp.found !== exp_rsp.found) begin
                        $display("%0t: found mismatch: expected %0d, actual %0d",
                                 $time, exp_rsp.found, i_rsp.found);
                        o_errors++;
                    end
                    if (i_rsp.data_out !== exp_rsp.data_out) begin
                        $display("%0t: data_out mismatch: expected %0d, actual %0d",
                                 $time, exp_rsp.data_out, i_rsp.data_out);
                        o_errors++;
                    end
                    if (i_rsp.status !== exp_rsp.status) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, exp_rsp.status, i_rsp.status);
                        o_errors++;
                    end
                end
            end
            if (i_start && !i_busy) rsp_expected.push_back(apply_request(i_req));
        end
        o_pending = rsp_expected.size();
    end

endmodule

/* tb/tb_hash_map_key_value_store.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb_hash_map_key_value_store
// Drives put/get/remove and unused-opcode requests into the hash map
// store: a directed set covering field extremes, misses, updates and a full
// bucket, then crowded-bucket random traffic in four phases, two with gaps.
// The checker predicts and compares; this module gives the verdict.
// ============================================================================
module tb_hash_map_key_value_store;

    localparam int          NUM_BUCKETS  = 64;
    localparam int          WAYS         = 8;
    localparam logic [1:0]  OP_UNUSED    = 2'd3;
    localparam logic [30:0] FIELD_MAX    = 31'h7FFF_FFFF;
    localparam int          PHASE_ITEMS  = 413;

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    logic           busy;
    hmkv_pkg::t_req i_req;
    logic           o_valid;
    hmkv_pkg::t_rsp o_rsp;
    int             errors;
    int             pending;

    hash_map_key_value_store #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .WAYS        (WAYS),
        .KEY_BITS    (31)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    hmkv_checker #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .WAYS        (WAYS)
    ) u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_busy    (busy),
        .i_req     (i_req),
        .i_valid   (o_valid),
        .i_rsp     (o_rsp),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("tb_hash_map_key_value_store: FAIL");
        $finish;
    end

    function automatic hmkv_pkg::t_req mk_req(logic [1:0] op, logic [30:0] key,
                                              logic [30:0] val);
        hmkv_pkg::t_req r;
        r.operation = hmkv_pkg::t_op'(op);
        r.key       = key;
        r.data_in   = val;
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_req(hmkv_pkg::t_req r, int idle_pct);
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        @(negedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Mostly keys crowding a few buckets with a dozen tags each, so buckets
    // overflow and hits are common.
    function automatic logic [30:0] crowded_key();
        logic [24:0] tag;
        logic [5:0]  bucket;
        int          t;
        if ($urandom_range(0, 99) < 12) return 31'($urandom() & FIELD_MAX);
        bucket = ($urandom_range(0, 1) == 0) ? 6'($urandom_range(0, 3))
                                              : 6'($urandom_range(60, 63));
        t   = $urandom_range(0, 11);
        tag = (t == 11) ? '1 : 25'(t * 25'h0A5_A5A5);
        return {tag, bucket};
    endfunction

    function automatic hmkv_pkg::t_req random_req();
        int          p;
        logic [1:0]  op;
        logic [30:0] val;
        p  = $urandom_range(0, 99);
        op = (p < 45) ? hmkv_pkg::OP_PUT : (p < 75) ? hmkv_pkg::OP_GET :
             (p < 95) ? hmkv_pkg::OP_REMOVE : OP_UNUSED;
        case ($urandom_range(0, 9))
            0:       val = '0;
            1:       val = FIELD_MAX;
            default: val = 31'($urandom() & FIELD_MAX);
        endcase
        return mk_req(op, crowded_key(), val);
    endfunction

    task automatic directed_reqs();
        send_req(mk_req(hmkv_pkg::OP_PUT, '0, '0), 0);
        send_req(mk_req(hmkv_pkg::OP_PUT, FIELD_MAX, FIELD_MAX), 0);
        send_req(mk_req(hmkv_pkg::OP_GET, '0, FIELD_MAX), 0);
        send_req(mk_req(hmkv_pkg::OP_GET, FIELD_MAX, '0), 0);
        send_req(mk_req(hmkv_pkg::OP_GET, 31'h7FFF_FFC0, '0), 0);
        send_req(mk_req(hmkv_pkg::OP_REMOVE, 31'h7FFF_FFC0, '0), 0);
        send_req(mk_req(hmkv_pkg::OP_PUT, FIELD_MAX, 31'h1234_5678), 0);
        send_req(mk_req(hmkv_pkg::OP_GET, FIELD_MAX, '0), 0);
        send_req(mk_req(OP_UNUSED, FIELD_MAX, FIELD_MAX), 0);
        // fill bucket 5 and overflow it
        for (int k = 0; k < WAYS + 1; k++)
            send_req(mk_req(hmkv_pkg::OP_PUT, 31'(5 + k * NUM_BUCKETS), 31'(100 + k)), 0);
        send_req(mk_req(hmkv_pkg::OP_PUT, 31'(5 + 3 * NUM_BUCKETS), 31'h5555_5555), 0);
        send_req(mk_req(hmkv_pkg::OP_REMOVE, 31'(5 + 2 * NUM_BUCKETS), '0), 0);
        send_req(mk_req(hmkv_pkg::OP_PUT, 31'(5 + WAYS * NUM_BUCKETS), 31'h2AAA_AAAA), 0);
        send_req(mk_req(hmkv_pkg::OP_GET, 31'(5 + WAYS * NUM_BUCKETS), '0), 0);
        send_req(mk_req(hmkv_pkg::OP_GET, 31'(5 + 2 * NUM_BUCKETS), '0), 0);
        send_req(mk_req(hmkv_pkg::OP_REMOVE, '0, FIELD_MAX), 0);
        send_req(mk_req(hmkv_pkg::OP_GET, '0, '0), 0);
        drain();
    endtask

    initial begin
        int idle_pct [4];
        idle_pct = '{0, 57, 22, 0};
        i_rst_n  = 1'b0;
        start    = 1'b0;
        i_req    = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed_reqs();

        foreach (idle_pct[ph]) begin
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_req(random_req(), idle_pct[ph]);
                if (ph == 1 && n == PHASE_ITEMS / 2) drain();
            end
            drain();
        end

        repeat (20) @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("tb_hash_map_key_value_store: PASS");
        end else begin
            $display("tb_hash_map_key_value_store: FAIL");
        end
        $finish;
    end

endmodule
